>>> rtl/core/pjq_pkg.sv
// Shared types and codes for the priority job queue with its recent-job stack.
// Used by pjq_qcell, pjq_rcell and the top level; depends on nothing.
package pjq_pkg;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  pri;
	} entry_t;

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_POP = 2'd2,
		OP_CLR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_Q_EMPTY = 3'd1,
		STS_Q_FULL  = 3'd2,
		STS_R_FULL  = 3'd3,
		STS_R_EMPTY = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_SCAN,
		FSM_PURGE,
		FSM_PUSH,
		FSM_RESP
	} fsm_t;

	typedef struct packed {
		logic shift;
		logic wr;
	} q_ctl_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} r_ctl_t;

	localparam int IN_W = 32;

endpackage

>>> rtl/core/priority_job_queue_with_recent_stack.sv
// Top level of the priority job queue: control sequencer, queue cell chain, recent stack
// cell chain and the result register. Depends on pjq_pkg, pjq_qcell and pjq_rcell.
//
//  channel   direction  fields (low bit first)
//  s_*       in         op[1:0], in_id[17:2], in_priority[25:18], zero pad to 32
//  m_*       out        out_id, out_priority, served, status, queue_count,
//                       recent_count, recent_top_id, recent_top_priority, zero pad
//
// Enqueue, pop, clear and a dequeue on an empty queue go from the execute step straight
// to the result step. A dequeue on a non-empty queue first rotates the queue chain once
// through its head cell to find the job and once more to drop its id, then pushes the
// job onto the recent stack.
// Reset empties both the queue and the recent stack at once; no clearing pass is needed.
// A new item is taken once the previous result sits in the output register; a stalled
// output holds the sequencer in its result step.
module priority_job_queue_with_recent_stack #(
	parameter int  QUEUE_DEPTH  = 16,
	parameter int  RECENT_DEPTH = 10,
	localparam int QW     = $clog2(QUEUE_DEPTH + 1),
	localparam int QI     = $clog2(QUEUE_DEPTH),
	localparam int RW     = $clog2(RECENT_DEPTH + 1),
	localparam int OUT_B  = 52 + QW + RW,
	localparam int OUT_W  = ((OUT_B + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// op, in_id, in_priority
	input  logic [pjq_pkg::IN_W-1:0] s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_id, out_priority, served, status, queue_count, recent_count,
	// recent_top_id, recent_top_priority
	output logic [OUT_W-1:0]       m_tdata
);

	pjq_pkg::fsm_t    state_q, state_d;
	pjq_pkg::op_t     op_q;
	logic [15:0]      id_q;
	logic [7:0]       pri_q;
	logic [QW-1:0]    qfill_q, cnt_q, k_q, tail_pos;
	logic [RW-1:0]    rfill_q;
	logic             first_q;
	pjq_pkg::entry_t  best_q;
	logic [15:0]      res_id_q;
	logic [7:0]       res_pri_q;
	logic             res_served_q;
	pjq_pkg::status_t res_status_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	pjq_pkg::entry_t  q_ent [QUEUE_DEPTH];
	pjq_pkg::entry_t  r_ent [RECENT_DEPTH];
	pjq_pkg::entry_t  head, q_wr_ent, new_ent, top;
	pjq_pkg::q_ctl_t  q_ctl;
	pjq_pkg::r_ctl_t  r_ctl;
	logic [QI-1:0]    q_wr_idx;
	logic             keep, q_full, r_full, out_load;

	assign head     = q_ent[0];
	assign keep     = head.id != best_q.id;
	assign q_full   = qfill_q == QW'(QUEUE_DEPTH);
	assign r_full   = rfill_q == RW'(RECENT_DEPTH);
	assign tail_pos = cnt_q + k_q - QW'(1);
	assign new_ent  = best_q;
	assign top      = (rfill_q != '0) ? r_ent[0] : '0;
	assign out_load = (state_q == pjq_pkg::FSM_RESP) && (!m_tvalid_q || m_tready);

	assign s_tready = state_q == pjq_pkg::FSM_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		state_d  = state_q;
		q_ctl    = '0;
		q_wr_idx = qfill_q[QI-1:0];
		q_wr_ent = '{id: id_q, pri: pri_q};
		r_ctl    = '0;
		unique case (state_q)
			pjq_pkg::FSM_IDLE: begin
				if (s_tvalid) begin
					state_d = pjq_pkg::FSM_EXEC;
				end
			end
			pjq_pkg::FSM_EXEC: begin
				state_d = pjq_pkg::FSM_RESP;
				unique case (op_q)
					pjq_pkg::OP_ENQ: q_ctl.wr = !q_full;
					pjq_pkg::OP_DEQ: begin
						if (qfill_q != '0) begin
							state_d = pjq_pkg::FSM_SCAN;
						end
					end
					pjq_pkg::OP_POP: r_ctl.pop = rfill_q != '0;
					pjq_pkg::OP_CLR: ;
				endcase
			end
			pjq_pkg::FSM_SCAN: begin
				q_ctl.shift = 1'b1;
				q_ctl.wr    = 1'b1;
				q_wr_idx    = tail_pos[QI-1:0];
				q_wr_ent    = head;
				if (cnt_q == QW'(1)) begin
					state_d = pjq_pkg::FSM_PURGE;
				end
			end
			pjq_pkg::FSM_PURGE: begin
				q_ctl.shift = 1'b1;
				q_ctl.wr    = keep;
				q_wr_idx    = tail_pos[QI-1:0];
				q_wr_ent    = head;
				if (cnt_q == QW'(1)) begin
					state_d = pjq_pkg::FSM_PUSH;
				end
			end
			pjq_pkg::FSM_PUSH: begin
				r_ctl.ins = !r_full;
				state_d   = pjq_pkg::FSM_RESP;
			end
			pjq_pkg::FSM_RESP: begin
				if (out_load) begin
					state_d = pjq_pkg::FSM_IDLE;
				end
			end
			default: state_d = pjq_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pjq_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qfill_q    <= '0;
			rfill_q    <= '0;
			cnt_q      <= '0;
			k_q        <= '0;
			first_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				pjq_pkg::FSM_EXEC: begin
					unique case (op_q)
						pjq_pkg::OP_ENQ: begin
							if (!q_full) begin
								qfill_q <= qfill_q + QW'(1);
							end
						end
						pjq_pkg::OP_DEQ: begin
							cnt_q   <= qfill_q;
							k_q     <= '0;
							first_q <= 1'b1;
						end
						pjq_pkg::OP_POP: begin
							if (rfill_q != '0) begin
								rfill_q <= rfill_q - RW'(1);
							end
						end
						pjq_pkg::OP_CLR: rfill_q <= '0;
					endcase
				end
				pjq_pkg::FSM_SCAN: begin
					first_q <= 1'b0;
					if (cnt_q == QW'(1)) begin
						cnt_q <= qfill_q;
						k_q   <= '0;
					end else begin
						cnt_q <= cnt_q - QW'(1);
						k_q   <= k_q + QW'(1);
					end
				end
				pjq_pkg::FSM_PURGE: begin
					cnt_q <= cnt_q - QW'(1);
					k_q   <= k_q + QW'(keep);
					if (cnt_q == QW'(1)) begin
						qfill_q <= k_q + QW'(keep);
					end
				end
				pjq_pkg::FSM_PUSH: begin
					if (!r_full) begin
						rfill_q <= rfill_q + RW'(1);
					end
				end
				default: ;
			endcase
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pjq_pkg::FSM_IDLE: begin
				op_q  <= pjq_pkg::op_t'(s_tdata[1:0]);
				id_q  <= s_tdata[17:2];
				pri_q <= s_tdata[25:18];
			end
			pjq_pkg::FSM_EXEC: begin
				res_id_q     <= '0;
				res_pri_q    <= '0;
				res_served_q <= 1'b0;
				res_status_q <= pjq_pkg::STS_OK;
				unique case (op_q)
					pjq_pkg::OP_ENQ: begin
						if (q_full) begin
							res_status_q <= pjq_pkg::STS_Q_FULL;
						end
					end
					pjq_pkg::OP_DEQ: begin
						if (qfill_q == '0) begin
							res_status_q <= pjq_pkg::STS_Q_EMPTY;
						end
					end
					pjq_pkg::OP_POP: begin
						if (rfill_q == '0) begin
							res_status_q <= pjq_pkg::STS_R_EMPTY;
						end
					end
					pjq_pkg::OP_CLR: ;
				endcase
			end
			pjq_pkg::FSM_SCAN: begin
				if (first_q || (head.pri > best_q.pri)) begin
					best_q <= head;
				end
			end
			pjq_pkg::FSM_PUSH: begin
				res_id_q     <= best_q.id;
				res_pri_q    <= best_q.pri;
				res_served_q <= 1'b1;
				res_status_q <= r_full ? pjq_pkg::STS_R_FULL : pjq_pkg::STS_OK;
			end
			default: ;
		endcase
		if (out_load) begin
			m_tdata_q <= OUT_W'({top.pri, top.id, rfill_q, qfill_q, res_status_q,
				res_served_q, res_pri_q, res_id_q});
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_q
		pjq_pkg::entry_t nxt;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nxt = q_wr_ent;
		end else begin : g_mid
			assign nxt = q_ent[i + 1];
		end
		pjq_qcell #(
			.IW  (QI),
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.ctl     (q_ctl),
			.wr_idx  (q_wr_idx),
			.wr_ent  (q_wr_ent),
			.nxt_ent (nxt),
			.ent     (q_ent[i])
		);
	end

	for (genvar i = 0; i < RECENT_DEPTH; i++) begin : g_r
		pjq_pkg::entry_t prv, nxt;
		if (i == 0) begin : g_first
			assign prv = new_ent;
		end else begin : g_prv
			assign prv = r_ent[i - 1];
		end
		if (i == RECENT_DEPTH - 1) begin : g_last
			assign nxt = r_ent[i];
		end else begin : g_nxt
			assign nxt = r_ent[i + 1];
		end
		pjq_rcell #(
			.CW  (RW),
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.ctl     (r_ctl),
			.fill    (rfill_q),
			.new_ent (new_ent),
			.prv_ent (prv),
			.nxt_ent (nxt),
			.ent     (r_ent[i])
		);
	end

	a_qfill_range: assert property (@(posedge clk) disable iff (!arst_n)
		qfill_q <= QW'(QUEUE_DEPTH))
		else $error("queue fill beyond depth");

	a_rfill_range: assert property (@(posedge clk) disable iff (!arst_n)
		rfill_q <= RW'(RECENT_DEPTH))
		else $error("recent fill beyond depth");

	a_purge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pjq_pkg::FSM_PURGE) |->
		(({1'b0, cnt_q} + {1'b0, k_q}) <= {1'b0, qfill_q}) && (cnt_q != '0))
		else $error("purge pass overruns the queue");

	a_take_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == pjq_pkg::FSM_EXEC))
		else $error("input transfer not followed by execution");

	if (RECENT_DEPTH > 1) begin : g_sorted_chk
		a_recent_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			(rfill_q >= RW'(2)) |-> (r_ent[0].pri >= r_ent[1].pri))
			else $error("recent stack out of order");
	end

endmodule

>>> rtl/core/pjq_qcell.sv
// One cell of the job queue chain: holds one entry, takes its neighbor's entry on a shift
// and loads the broadcast entry when the write position names this cell. Depends on pjq_pkg.
module pjq_qcell #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic            clk,
	input  pjq_pkg::q_ctl_t ctl,
	input  logic [IW-1:0]   wr_idx,
	input  pjq_pkg::entry_t wr_ent,
	input  pjq_pkg::entry_t nxt_ent,
	output pjq_pkg::entry_t ent
);

	pjq_pkg::entry_t ent_q;
	logic            hit;

	assign hit = ctl.wr && (wr_idx == IW'(IDX));
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (hit) begin
			ent_q <= wr_ent;
		end else if (ctl.shift) begin
			ent_q <= nxt_ent;
		end
	end

endmodule

>>> rtl/core/pjq_rcell.sv
// One cell of the recent stack chain, kept sorted with the top in cell zero.
// An insert is decided locally from this cell and the one above it. Depends on pjq_pkg.
module pjq_rcell #(
	parameter int CW  = 4,
	parameter int IDX = 0
) (
	input  logic            clk,
	input  pjq_pkg::r_ctl_t ctl,
	input  logic [CW-1:0]   fill,
	input  pjq_pkg::entry_t new_ent,
	input  pjq_pkg::entry_t prv_ent,
	input  pjq_pkg::entry_t nxt_ent,
	output pjq_pkg::entry_t ent
);

	pjq_pkg::entry_t ent_q;
	logic            keep;
	logic            prv_ge;

	assign keep   = (fill > CW'(IDX)) && (ent_q.pri >= new_ent.pri);
	assign prv_ge = (IDX == 0) || (prv_ent.pri >= new_ent.pri);
	assign ent    = ent_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!keep) begin
				ent_q <= prv_ge ? new_ent : prv_ent;
			end
		end else if (ctl.pop) begin
			ent_q <= nxt_ent;
		end
	end

endmodule

>>> dv/tb.sv
// Self-checking bench for priority_job_queue_with_recent_stack: a directed opening, then
// random bursts of job traffic under changing backpressure, checked against an in-bench model.
// Depends on pjq_pkg and the top-level RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH      = 16;
	localparam int RDEPTH      = 10;
	localparam int RAND_ITEMS  = 1150;
	localparam int QUIET_LIMIT = 5000;

	typedef struct {
		pjq_pkg::op_t op;
		logic [15:0]  id;
		logic [7:0]   pri;
		bit           hold;
	} job_req_t;

	typedef struct packed {
		logic [7:0]       top_pri;
		logic [15:0]      top_id;
		logic [3:0]       recent_cnt;
		logic [4:0]       queue_cnt;
		pjq_pkg::status_t status;
		logic             served;
		logic [7:0]       out_pri;
		logic [15:0]      out_id;
	} job_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;

	job_req_t        job_feed[$];
	job_resp_t       pending_responses[$];
	job_req_t        cur_req;
	pjq_pkg::entry_t queue_model[QDEPTH];
	pjq_pkg::entry_t recent_model[RDEPTH];
	int              queue_fill;
	int              recent_fill;
	int              resp_due;
	int              resp_checked;
	int              total_items;
	int              idle_phase;
	int              quiet_cycles;
	int              errors;
	int              op_tally[4];
	int              status_tally[8];
	int              jobs_served;
	int              max_recent;

	priority_job_queue_with_recent_stack #(
		.QUEUE_DEPTH (QDEPTH),
		.RECENT_DEPTH(RDEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic job_resp_t apply_job_op(pjq_pkg::op_t op, logic [15:0] id,
		logic [7:0] pri);
		job_resp_t       r;
		pjq_pkg::entry_t best;
		int              k;
		int              pos;
		r = '0;
		r.status = pjq_pkg::STS_OK;
		op_tally[op]++;
		case (op)
			pjq_pkg::OP_ENQ: begin
				if (queue_fill >= QDEPTH) begin
					r.status = pjq_pkg::STS_Q_FULL;
				end else begin
					queue_model[queue_fill] = '{id: id, pri: pri};
					queue_fill++;
				end
			end
			pjq_pkg::OP_DEQ: begin
				if (queue_fill == 0) begin
					r.status = pjq_pkg::STS_Q_EMPTY;
				end else begin
					best = queue_model[0];
					for (int i = 1; i < queue_fill; i++)
						if (queue_model[i].pri > best.pri)
							best = queue_model[i];
					k = 0;
					for (int i = 0; i < queue_fill; i++)
						if (queue_model[i].id != best.id) begin
							queue_model[k] = queue_model[i];
							k++;
						end
					queue_fill = k;
					r.out_id = best.id;
					r.out_pri = best.pri;
					r.served = 1'b1;
					jobs_served++;
					if (recent_fill >= RDEPTH) begin
						r.status = pjq_pkg::STS_R_FULL;
					end else begin
						pos = 0;
						for (int i = recent_fill; i > 0; i--)
							if (pos == 0 && best.pri > recent_model[i - 1].pri)
								pos = i;
						for (int i = recent_fill; i > pos; i--)
							recent_model[i] = recent_model[i - 1];
						recent_model[pos] = best;
						recent_fill++;
					end
				end
			end
			pjq_pkg::OP_POP: begin
				if (recent_fill == 0)
					r.status = pjq_pkg::STS_R_EMPTY;
				else
					recent_fill--;
			end
			default: begin
				recent_fill = 0;
			end
		endcase
		r.queue_cnt = 5'(queue_fill);
		r.recent_cnt = 4'(recent_fill);
		if (recent_fill > 0) begin
			r.top_id = recent_model[recent_fill - 1].id;
			r.top_pri = recent_model[recent_fill - 1].pri;
		end
		if (recent_fill > max_recent)
			max_recent = recent_fill;
		status_tally[r.status]++;
		return r;
	endfunction

	function automatic void note_error(string what);
		errors++;
		if (errors <= 10)
			$display("%0t ERROR: %s", $realtime, what);
	endfunction

	task automatic add_req(pjq_pkg::op_t op, logic [15:0] id, logic [7:0] pri, bit hold);
		job_feed.push_back('{op: op, id: id, pri: pri, hold: hold});
	endtask

	// Sender side: presents queued jobs and models each one as it is taken.
	always @(posedge clk or negedge arst_n) begin
		bit go;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			idle_phase <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_responses.push_back(apply_job_op(cur_req.op, cur_req.id, cur_req.pri));
				resp_due++;
				idle_phase <= (resp_due * 3) / total_items;
			end
			if (!s_tvalid || s_tready) begin
				go = job_feed.size() != 0;
				if (go && $urandom_range(99) < (idle_phase == 0 ? 38 : idle_phase == 1 ? 69 : 0))
					go = 1'b0;
				if (go && job_feed[0].hold && resp_due != resp_checked)
					go = 1'b0;
				if (go) begin
					cur_req = job_feed.pop_front();
					s_tdata <= {6'b0, cur_req.pri, cur_req.id, cur_req.op};
				end
				s_tvalid <= go;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= $urandom_range(99) >= (idle_phase == 0 ? 69 : idle_phase == 1 ? 38 : 0);
	end

	always @(posedge clk) begin
		job_resp_t want;
		job_resp_t got;
		if (arst_n && m_tvalid && m_tready) begin
			resp_checked <= resp_checked + 1;
			got = m_tdata[60:0];
			if (pending_responses.size() == 0) begin
				note_error($sformatf("result with nothing expected: %h", m_tdata));
			end else begin
				want = pending_responses.pop_front();
				if (m_tdata !== {3'b0, want})
					note_error($sformatf({"result mismatch\n",
						"  exp id=%h pri=%h served=%b status=%s qcnt=%0d rcnt=%0d top=%h/%h\n",
						"  got id=%h pri=%h served=%b status=%0d qcnt=%0d rcnt=%0d top=%h/%h",
						" pad=%b"},
						want.out_id, want.out_pri, want.served, want.status.name(),
						want.queue_cnt, want.recent_cnt, want.top_id, want.top_pri,
						got.out_id, got.out_pri, got.served, got.status, got.queue_cnt,
						got.recent_cnt, got.top_id, got.top_pri, m_tdata[63:61]));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t timeout: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int           mode;
		int           len;
		int           w;
		pjq_pkg::op_t op;
		logic [15:0]  id;
		logic [7:0]   pri;

		// Empty-structure cases, then a full queue with duplicate ids and ties.
		add_req(pjq_pkg::OP_DEQ, 16'h0000, 8'h00, 1'b0);
		add_req(pjq_pkg::OP_POP, 16'hffff, 8'hff, 1'b0);
		add_req(pjq_pkg::OP_CLR, 16'h0000, 8'h00, 1'b0);
		add_req(pjq_pkg::OP_ENQ, 16'h0000, 8'h00, 1'b0);
		add_req(pjq_pkg::OP_ENQ, 16'hffff, 8'hff, 1'b0);
		add_req(pjq_pkg::OP_ENQ, 16'hffff, 8'h00, 1'b0);
		for (int i = 0; i < 13; i++)
			add_req(pjq_pkg::OP_ENQ, 16'(16'h0100 + i), 8'((i % 3) * 8'h40), 1'b0);
		add_req(pjq_pkg::OP_ENQ, 16'haaaa, 8'h55, 1'b0);
		add_req(pjq_pkg::OP_DEQ, 16'h5555, 8'haa, 1'b0);
		add_req(pjq_pkg::OP_DEQ, 16'h0000, 8'h00, 1'b0);
		add_req(pjq_pkg::OP_POP, 16'h0000, 8'h00, 1'b0);
		add_req(pjq_pkg::OP_DEQ, 16'h0000, 8'h00, 1'b0);
		add_req(pjq_pkg::OP_CLR, 16'hffff, 8'hff, 1'b0);

		// Bursts that fill, drain or mix; small id and priority pools force duplicates and ties.
		w = job_feed.size();
		while (job_feed.size() < w + RAND_ITEMS) begin
			mode = $urandom_range(9);
			len = $urandom_range(20, 4);
			for (int n = 0; n < len; n++) begin
				w = $urandom_range(99);
				if (mode <= 3)
					op = w < 85 ? pjq_pkg::OP_ENQ : pjq_pkg::OP_DEQ;
				else if (mode <= 6)
					op = w < 75 ? pjq_pkg::OP_DEQ : w < 90 ? pjq_pkg::OP_POP : pjq_pkg::OP_ENQ;
				else if (mode <= 8)
					op = w < 40 ? pjq_pkg::OP_ENQ : w < 75 ? pjq_pkg::OP_DEQ :
						w < 95 ? pjq_pkg::OP_POP : pjq_pkg::OP_CLR;
				else
					op = pjq_pkg::op_t'($urandom_range(3));
				w = $urandom_range(99);
				id = w < 60 ? 16'($urandom_range(7)) :
					w < 80 ? ($urandom_range(1) ? 16'hffff : 16'h0001 << $urandom_range(15)) :
					16'($urandom);
				w = $urandom_range(99);
				pri = w < 50 ? 8'($urandom_range(3)) :
					w < 70 ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
				add_req(op, id, pri, n == 0 && $urandom_range(7) == 0);
			end
			w = 25;
		end
		job_feed[25].hold = 1'b1;
		total_items = job_feed.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (job_feed.size() != 0 || s_tvalid || resp_checked != resp_due)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (pending_responses.size() != 0)
			note_error($sformatf("%0d results never arrived", pending_responses.size()));

		$display("Covered %0d jobs: %0d enqueue, %0d dequeue (%0d served), %0d pop, %0d clear.",
			resp_due, op_tally[pjq_pkg::OP_ENQ], op_tally[pjq_pkg::OP_DEQ], jobs_served,
			op_tally[pjq_pkg::OP_POP], op_tally[pjq_pkg::OP_CLR]);
		$display({"Flags seen: queue empty %0d, queue full %0d, stack full %0d, ",
			"stack empty %0d; deepest stack %0d; %0d errors."},
			status_tally[pjq_pkg::STS_Q_EMPTY], status_tally[pjq_pkg::STS_Q_FULL],
			status_tally[pjq_pkg::STS_R_FULL], status_tally[pjq_pkg::STS_R_EMPTY],
			max_recent, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
rtl/core/pjq_pkg.sv
rtl/core/pjq_qcell.sv
rtl/core/pjq_rcell.sv
rtl/core/priority_job_queue_with_recent_stack.sv
dv/tb.sv
